// ----- rtl/sdtq_pkg.sv -----
// ----------------------------------------------------------------------------
// sdtq_pkg
// Shared types and constants for the sorted deadline timer queue.
// ----------------------------------------------------------------------------
`default_nettype none

package sdtq_pkg;

   localparam int FIELD_TIME_WIDTH = 32;
   localparam int HANDLE_WIDTH     = 4;
   localparam int HANDLE_COUNT     = 16;
   localparam int KIND_WIDTH       = 2;
   localparam int STATUS_WIDTH     = 3;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_ADD    = 2'd0,
      KIND_CANCEL = 2'd1,
      KIND_TIME   = 2'd2
   } kind_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_ADDED     = 3'd0,
      STATUS_FULL      = 3'd1,
      STATUS_CANCELLED = 3'd2,
      STATUS_UNKNOWN   = 3'd3,
      STATUS_EXPIRED   = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CELL_NOP    = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_CANCEL = 2'd2,
      CELL_POP    = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type             op;
      logic [HANDLE_WIDTH-1:0] handle;
   } cell_cmd_type;

   // {none free, lowest clear index}
   function automatic logic [HANDLE_WIDTH:0] lowest_free(
      input logic [HANDLE_COUNT-1:0] map
   );
      logic [HANDLE_WIDTH:0] res;
      res = {1'b1, {HANDLE_WIDTH{1'b0}}};
      for (int i = HANDLE_COUNT - 1; i >= 0; i--) begin
         if (!map[i]) begin
            res = {1'b0, HANDLE_WIDTH'(i)};
         end
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/sdtq_if.sv -----
// ----------------------------------------------------------------------------
// sdtq_if
// Request and response channel interfaces (valid/ready).
// ----------------------------------------------------------------------------
`default_nettype none

interface sdtq_req_if import sdtq_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic [KIND_WIDTH-1:0]       kind;
   logic [FIELD_TIME_WIDTH-1:0] time_value;
   logic [HANDLE_WIDTH-1:0]     handle;

   modport source (output valid, kind, time_value, handle, input ready);
   modport sink   (input valid, kind, time_value, handle, output ready);
endinterface

interface sdtq_rsp_if import sdtq_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic [STATUS_WIDTH-1:0]     status;
   logic [HANDLE_WIDTH-1:0]     timer_handle;
   logic [FIELD_TIME_WIDTH-1:0] next_deadline;
   logic                        queue_empty;
   logic                        last;

   modport source (output valid, status, timer_handle, next_deadline, queue_empty, last,
                   input ready);
   modport sink   (input valid, status, timer_handle, next_deadline, queue_empty, last,
                   output ready);
endinterface

`default_nettype wire

// ----- rtl/sdtq_cell.sv -----
// ----------------------------------------------------------------------------
// sdtq_cell
// One slot of the sorted shift queue. Inserts shift right from the insert
// point, removals shift left from the removed slot.
// ----------------------------------------------------------------------------
`default_nettype none

module sdtq_cell import sdtq_pkg::*; #(
   parameter int TIME_WIDTH = 32
) (
   input  wire                     clock,
   input  wire                     reset,
   input  cell_cmd_type            cmd,
   input  wire [TIME_WIDTH-1:0]    new_deadline,
   input  wire                     left_valid,
   input  wire [TIME_WIDTH-1:0]    left_deadline,
   input  wire [HANDLE_WIDTH-1:0]  left_handle,
   input  wire                     left_ins,
   input  wire                     right_valid,
   input  wire [TIME_WIDTH-1:0]    right_deadline,
   input  wire [HANDLE_WIDTH-1:0]  right_handle,
   input  wire                     kill_in,
   output logic                    valid,
   output logic [TIME_WIDTH-1:0]   deadline,
   output logic [HANDLE_WIDTH-1:0] handle,
   output logic                    ins,
   output logic                    kill_out,
   output logic                    next_valid,
   output logic [TIME_WIDTH-1:0]   next_deadline
);

   logic                    valid_ff, valid_in;
   logic [TIME_WIDTH-1:0]   deadline_ff, deadline_in;
   logic [HANDLE_WIDTH-1:0] handle_ff, handle_in;

   always_comb begin
      // new timer goes in front of the first later deadline or empty slot
      ins      = !valid_ff || (deadline_ff > new_deadline);
      kill_out = kill_in ||
                 ((cmd.op == CELL_CANCEL) && valid_ff && (handle_ff == cmd.handle));

      valid_in    = valid_ff;
      deadline_in = deadline_ff;
      handle_in   = handle_ff;
      case (cmd.op)
         CELL_INSERT: begin
            if (ins) begin
               if (left_ins) begin
                  valid_in    = left_valid;
                  deadline_in = left_deadline;
                  handle_in   = left_handle;
               end else begin
                  valid_in    = 1'b1;
                  deadline_in = new_deadline;
                  handle_in   = cmd.handle;
               end
            end
         end
         CELL_CANCEL, CELL_POP: begin
            if (kill_out) begin
               valid_in    = right_valid;
               deadline_in = right_deadline;
               handle_in   = right_handle;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      deadline_ff <= deadline_in;
      handle_ff   <= handle_in;
   end

   assign valid         = valid_ff;
   assign deadline      = deadline_ff;
   assign handle        = handle_ff;
   assign next_valid    = valid_in;
   assign next_deadline = deadline_in;

endmodule

`default_nettype wire

// ----- rtl/sorted_deadline_timer_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_deadline_timer_queue
// Bounded timer queue kept sorted by deadline in a row of shift cells.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                             flow
//  req_chan  in   kind, time_value, handle                            valid/ready
//  rsp_chan  out  status, timer_handle, next_deadline, queue_empty,   valid/ready
//                 last
//
//  A request is held in a one-entry request register and worked on from
//  there; add and cancel each need one cell-row update, so one transaction
//  per cycle while responses are drained. A time event gives one response
//  per expired timer, each with one cell-row shift, then a closing
//  response. Work waits only on the response register. Reset clears the
//  cell valid bits, count, handle map, and request/response valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_deadline_timer_queue import sdtq_pkg::*; #(
   parameter int QUEUE_DEPTH = 16,
   parameter int TIME_WIDTH  = 32
) (
   input  wire        clock,
   input  wire        reset,
   sdtq_req_if.sink   req_chan,
   sdtq_rsp_if.source rsp_chan
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   // request register
   logic                    op_valid_ff;
   logic [KIND_WIDTH-1:0]   op_kind_ff;
   logic [TIME_WIDTH-1:0]   op_time_ff;
   logic [HANDLE_WIDTH-1:0] op_handle_ff;
   logic [TIME_WIDTH-1:0]   req_time;

   // queue bookkeeping
   logic [CW-1:0]           count_ff, count_in;
   logic [HANDLE_COUNT-1:0] in_use_ff, in_use_in;

   // response register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [STATUS_WIDTH-1:0]     rsp_status_ff, rsp_status_in;
   logic [HANDLE_WIDTH-1:0]     rsp_handle_ff, rsp_handle_in;
   logic [FIELD_TIME_WIDTH-1:0] rsp_next_ff, rsp_next_in;
   logic                        rsp_empty_ff, rsp_empty_in;
   logic                        rsp_last_ff, rsp_last_in;

   // cell row
   cell_cmd_type            cmd;
   logic                    valid_q    [QUEUE_DEPTH];
   logic [TIME_WIDTH-1:0]   deadline_q [QUEUE_DEPTH];
   logic [HANDLE_WIDTH-1:0] handle_q   [QUEUE_DEPTH];
   logic                    ins_q      [QUEUE_DEPTH];
   logic                    kill_q     [QUEUE_DEPTH];
   logic                    nvalid_q   [QUEUE_DEPTH];
   logic [TIME_WIDTH-1:0]   ndeadline_q[QUEUE_DEPTH];

   logic                    out_free, act, done, pop, full, cancel_hit;
   logic [HANDLE_WIDTH:0]   free_slot;
   logic [FIELD_TIME_WIDTH-1:0] head_time;

   generate
      if (TIME_WIDTH <= FIELD_TIME_WIDTH) begin : g_narrow
         assign req_time  = req_chan.time_value[TIME_WIDTH-1:0];
         assign head_time = FIELD_TIME_WIDTH'(ndeadline_q[0]);
      end else begin : g_wide
         assign req_time  = {{(TIME_WIDTH-FIELD_TIME_WIDTH){1'b0}}, req_chan.time_value};
         assign head_time = ndeadline_q[0][FIELD_TIME_WIDTH-1:0];
      end
   endgenerate

   genvar gi;
   generate
      for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
         logic                    l_valid, l_ins, r_valid, k_in;
         logic [TIME_WIDTH-1:0]   l_deadline, r_deadline;
         logic [HANDLE_WIDTH-1:0] l_handle, r_handle;

         if (gi == 0) begin : g_head
            assign l_valid    = 1'b0;
            assign l_deadline = '0;
            assign l_handle   = '0;
            assign l_ins      = 1'b0;
            assign k_in       = (cmd.op == CELL_POP);
         end else begin : g_body
            assign l_valid    = valid_q[gi-1];
            assign l_deadline = deadline_q[gi-1];
            assign l_handle   = handle_q[gi-1];
            assign l_ins      = ins_q[gi-1];
            assign k_in       = kill_q[gi-1];
         end

         if (gi == QUEUE_DEPTH - 1) begin : g_tail
            assign r_valid    = 1'b0;
            assign r_deadline = '0;
            assign r_handle   = '0;
         end else begin : g_inner
            assign r_valid    = valid_q[gi+1];
            assign r_deadline = deadline_q[gi+1];
            assign r_handle   = handle_q[gi+1];
         end

         sdtq_cell #(
            .TIME_WIDTH (TIME_WIDTH)
         ) u_cell (
            .clock          (clock),
            .reset          (reset),
            .cmd            (cmd),
            .new_deadline   (op_time_ff),
            .left_valid     (l_valid),
            .left_deadline  (l_deadline),
            .left_handle    (l_handle),
            .left_ins       (l_ins),
            .right_valid    (r_valid),
            .right_deadline (r_deadline),
            .right_handle   (r_handle),
            .kill_in        (k_in),
            .valid          (valid_q[gi]),
            .deadline       (deadline_q[gi]),
            .handle         (handle_q[gi]),
            .ins            (ins_q[gi]),
            .kill_out       (kill_q[gi]),
            .next_valid     (nvalid_q[gi]),
            .next_deadline  (ndeadline_q[gi])
         );
      end
   endgenerate

   always_comb begin
      out_free   = !rsp_valid_ff || rsp_chan.ready;
      free_slot  = lowest_free(in_use_ff);
      full       = (count_ff >= CW'(QUEUE_DEPTH)) || free_slot[HANDLE_WIDTH];
      cancel_hit = in_use_ff[op_handle_ff];
      pop        = valid_q[0] && (deadline_q[0] <= op_time_ff);

      act  = 1'b0;
      done = 1'b0;
      cmd  = '{op: CELL_NOP, handle: op_handle_ff};

      count_in      = count_ff;
      in_use_in     = in_use_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_last_in   = rsp_last_ff;

      if (op_valid_ff) begin
         case (op_kind_ff)
            KIND_ADD: begin
               act           = out_free;
               done          = out_free;
               rsp_status_in = full ? STATUS_FULL : STATUS_ADDED;
               rsp_handle_in = full ? '0 : free_slot[HANDLE_WIDTH-1:0];
               rsp_last_in   = 1'b1;
               if (out_free && !full) begin
                  cmd.op    = CELL_INSERT;
                  cmd.handle = free_slot[HANDLE_WIDTH-1:0];
                  count_in  = count_ff + CW'(1);
                  in_use_in[free_slot[HANDLE_WIDTH-1:0]] = 1'b1;
               end
            end
            KIND_CANCEL: begin
               act           = out_free;
               done          = out_free;
               rsp_status_in = cancel_hit ? STATUS_CANCELLED : STATUS_UNKNOWN;
               rsp_handle_in = op_handle_ff;
               rsp_last_in   = 1'b1;
               if (out_free && cancel_hit) begin
                  cmd.op   = CELL_CANCEL;
                  count_in = count_ff - CW'(1);
                  in_use_in[op_handle_ff] = 1'b0;
               end
            end
            KIND_TIME: begin
               // one expired timer per cycle while the response register is free, then the closing transaction
               act           = out_free;
               done          = out_free && !pop;
               rsp_status_in = STATUS_EXPIRED;
               rsp_handle_in = pop ? handle_q[0] : '0;
               rsp_last_in   = !pop;
               if (out_free && pop) begin
                  cmd.op   = CELL_POP;
                  count_in = count_ff - CW'(1);
                  in_use_in[handle_q[0]] = 1'b0;
               end
            end
            default: begin
               done = 1'b1;
            end
         endcase
      end

      if (act) begin
         rsp_valid_in = 1'b1;
      end
      rsp_next_in  = nvalid_q[0] ? head_time : '0;
      rsp_empty_in = !nvalid_q[0];

      req_chan.ready = !op_valid_ff || done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_valid_ff  <= 1'b0;
         count_ff     <= '0;
         in_use_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            op_valid_ff <= 1'b1;
         end else if (done) begin
            op_valid_ff <= 1'b0;
         end
         count_ff     <= count_in;
         in_use_ff    <= in_use_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         op_kind_ff   <= req_chan.kind;
         op_time_ff   <= req_time;
         op_handle_ff <= req_chan.handle;
      end
      if (act) begin
         rsp_status_ff <= rsp_status_in;
         rsp_handle_ff <= rsp_handle_in;
         rsp_next_ff   <= rsp_next_in;
         rsp_empty_ff  <= rsp_empty_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.timer_handle  = rsp_handle_ff;
   assign rsp_chan.next_deadline = rsp_next_ff;
   assign rsp_chan.queue_empty   = rsp_empty_ff;
   assign rsp_chan.last          = rsp_last_ff;

endmodule

`default_nettype wire
